### rtl/bgm_pkg.sv
// shared types and constants for the greedy bipartite matching core
// no dependencies
`default_nettype none

package bgm_pkg;

  localparam int MAX_A = 64;
  localparam int MAX_B = 64;

  // vertex numbers are 1-based and carry one bit more than a row index
  localparam int VTX_W = 7;
  localparam int ROW_W = $clog2(MAX_A);
  localparam int COL_W = $clog2(MAX_B);
  localparam int GRP_W = 3;
  localparam int GRP_N = 1 << GRP_W;
  localparam int SUB_W = COL_W - GRP_W;
  localparam int SUB_N = 1 << SUB_W;

  localparam logic [VTX_W-1:0] MAX_A_V = VTX_W'(MAX_A);
  localparam logic [VTX_W-1:0] MAX_B_V = VTX_W'(MAX_B);

  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_PAIR    = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 1'b1;

  // request into the adjacency store
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [ROW_W-1:0] addr;
    logic [MAX_B-1:0] wdata;
  } adj_req_t;

endpackage

`default_nettype wire

### rtl/bipartite_greedy_matching_core.sv
// edge update: a store read state, then a store write state that registers the result once the
// output is free (an invalid vertex skips the read); input stalled until back in idle; cmd 3 is
// absorbed with no result. run: per side A row walked, one adjacency store read state and one
// search state, then a closing state for the last result; the walk may wait while the result
// channel stalls
// synchronous active-low reset: adjacency row valid bits cleared, sizes back to 64
`default_nettype none

module bipartite_greedy_matching_core
  import bgm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [VTX_W-1:0]     in_vertex_a,
  input  wire logic [VTX_W-1:0]     in_vertex_b,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [STAT_W-1:0]    out_status,
  output logic      [VTX_W-1:0]     out_pair_a,
  output logic      [VTX_W-1:0]     out_pair_b,
  output logic                      out_last,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VTX_W-1:0]     cfg_wdata
);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EDGE_RD  = 6'b000010,
    S_EDGE_WR  = 6'b000100,
    S_RUN_RD   = 6'b001000,
    S_RUN_EVAL = 6'b010000,
    S_RUN_END  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // size registers and the effective sizes saturated to the array bounds
  logic [VTX_W-1:0] count_a_r, count_b_r;
  logic [VTX_W-1:0] na, nb;

  // latched edge transaction
  logic [CMD_W-1:0] cmd_r;
  logic [VTX_W-1:0] va_r, vb_r;
  logic             inval_r, inval_nxt;

  // run state: row cursor, free side B mask, pending pair held back for the last mark
  logic [VTX_W-1:0] row_r, row_nxt;
  logic [MAX_B-1:0] free_r, free_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [VTX_W-1:0] pend_a_r, pend_a_nxt;
  logic [VTX_W-1:0] pend_b_r, pend_b_nxt;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VTX_W-1:0]  out_pair_a_r, out_pair_a_nxt;
  logic [VTX_W-1:0]  out_pair_b_r, out_pair_b_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;
  logic              slot_free;

  logic             in_acc;
  logic             in_ok;
  logic [MAX_B-1:0] init_mask;
  logic [VTX_W-1:0] va_m1, vb_m1;
  logic [MAX_B-1:0] edge_bit;
  logic [MAX_B-1:0] cand;
  logic             cand_found;
  logic [COL_W-1:0] cand_idx;
  logic [MAX_B-1:0] cand_bit;
  logic [VTX_W-1:0] row_inc;

  adj_req_t         adj_req;
  logic [MAX_B-1:0] adj_rdata;

  bgm_adj_ram u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (adj_req),
    .rdata (adj_rdata)
  );

  // shared search unit, used once per walked row
  bgm_low_bit u_find (
    .vec   (cand),
    .found (cand_found),
    .idx   (cand_idx)
  );

  assign na = (count_a_r > MAX_A_V) ? MAX_A_V : count_a_r;
  assign nb = (count_b_r > MAX_B_V) ? MAX_B_V : count_b_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  // a size write never lands in the same cycle as an input transaction
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign slot_free = !out_valid_r || !out_stall;

  // both vertex numbers in 1..size
  assign in_ok = (in_vertex_a != '0) && (in_vertex_a <= na) &&
                 (in_vertex_b != '0) && (in_vertex_b <= nb);

  // in-use side B vertices are free at the start of a run
  always_comb begin
    for (int i = 0; i < MAX_B; i++) begin
      init_mask[i] = (nb > VTX_W'(i));
    end
  end

  assign va_m1    = va_r - VTX_W'(1);
  assign vb_m1    = vb_r - VTX_W'(1);
  assign edge_bit = MAX_B'(1) << vb_m1[COL_W-1:0];

  assign cand     = adj_rdata & free_r;
  assign cand_bit = MAX_B'(1) << cand_idx;
  assign row_inc  = row_r + VTX_W'(1);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    inval_nxt      = inval_r;
    row_nxt        = row_r;
    free_nxt       = free_r;
    pend_vld_nxt   = pend_vld_r;
    pend_a_nxt     = pend_a_r;
    pend_b_nxt     = pend_b_r;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_pair_a_nxt = '0;
    out_pair_b_nxt = '0;
    out_last_nxt   = 1'b1;
    adj_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd) inside
            CMD_ADD, CMD_DEL: begin
              inval_nxt = !in_ok;
              // an invalid vertex skips the store read
              state_nxt = in_ok ? S_EDGE_RD : S_EDGE_WR;
            end
            CMD_RUN: begin
              free_nxt     = init_mask;
              row_nxt      = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = (na == '0) ? S_RUN_END : S_RUN_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_EDGE_RD: begin
        adj_req.rd_en = 1'b1;
        adj_req.addr  = va_m1[ROW_W-1:0];
        state_nxt     = S_EDGE_WR;
      end

      S_EDGE_WR: begin
        adj_req.addr  = va_m1[ROW_W-1:0];
        adj_req.wdata = (cmd_r == CMD_ADD) ? (adj_rdata | edge_bit) : (adj_rdata & ~edge_bit);
        if (slot_free) begin
          adj_req.wr_en  = !inval_r;
          out_load       = 1'b1;
          out_status_nxt = inval_r ? ST_INVALID : ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      S_RUN_RD: begin
        adj_req.rd_en = 1'b1;
        adj_req.addr  = row_r[ROW_W-1:0];
        state_nxt     = S_RUN_EVAL;
      end

      S_RUN_EVAL: begin
        // a new pair pushes the held one out, wait if the output is still full
        if (!(cand_found && pend_vld_r && !slot_free)) begin
          if (cand_found) begin
            free_nxt     = free_r & ~cand_bit;
            pend_vld_nxt = 1'b1;
            pend_a_nxt   = row_inc;
            pend_b_nxt   = VTX_W'(cand_idx) + VTX_W'(1);
            if (pend_vld_r) begin
              out_load       = 1'b1;
              out_status_nxt = ST_PAIR;
              out_pair_a_nxt = pend_a_r;
              out_pair_b_nxt = pend_b_r;
              out_last_nxt   = 1'b0;
            end
          end
          row_nxt   = row_inc;
          state_nxt = (row_inc == na) ? S_RUN_END : S_RUN_RD;
        end
      end

      S_RUN_END: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pend_vld_r) begin
            out_status_nxt = ST_PAIR;
            out_pair_a_nxt = pend_a_r;
            out_pair_b_nxt = pend_b_r;
          end else begin
            out_status_nxt = ST_EMPTY;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      row_r       <= '0;
      free_r      <= '0;
      count_a_r   <= MAX_A_V;
      count_b_r   <= MAX_B_V;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      row_r      <= row_nxt;
      free_r     <= free_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_COUNT_A: count_a_r <= cfg_wdata;
          REG_COUNT_B: count_b_r <= cfg_wdata;
          default:     count_a_r <= count_a_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_cmd;
      va_r  <= in_vertex_a;
      vb_r  <= in_vertex_b;
    end
    inval_r  <= inval_nxt;
    pend_a_r <= pend_a_nxt;
    pend_b_r <= pend_b_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_pair_a_r <= out_pair_a_nxt;
      out_pair_b_r <= out_pair_b_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pair_a = out_pair_a_r;
  assign out_pair_b = out_pair_b_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### rtl/bgm_adj_ram.sv
// adjacency store: one row per side A vertex, one read or write port
// depends on bgm_pkg
`default_nettype none

module bgm_adj_ram
  import bgm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire adj_req_t         req,
  output logic      [MAX_B-1:0] rdata
);

  logic [MAX_B-1:0] mem [MAX_A];
  logic [MAX_A-1:0] vld_r;
  logic [MAX_B-1:0] rdata_r;

  // row valid bits, a row never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= vld_r[req.addr] ? mem[req.addr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/bgm_low_bit.sv
// lowest set bit search over one candidate row, two 8-way levels
// depends on bgm_pkg
`default_nettype none

module bgm_low_bit
  import bgm_pkg::*;
(
  input  wire logic [MAX_B-1:0] vec,
  output logic                  found,
  output logic      [COL_W-1:0] idx
);

  logic [GRP_N-1:0] grp_any;
  logic [GRP_W-1:0] grp_sel;
  logic [SUB_N-1:0] sub_vec;
  logic [SUB_W-1:0] sub_sel;

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |vec[g*SUB_N +: SUB_N];
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GRP_W'(g);
      end
    end
  end

  assign sub_vec = vec[grp_sel*SUB_N +: SUB_N];

  always_comb begin
    sub_sel = '0;
    for (int s = SUB_N - 1; s >= 0; s--) begin
      if (sub_vec[s]) begin
        sub_sel = SUB_W'(s);
      end
    end
  end

  assign found = |grp_any;
  assign idx   = {grp_sel, sub_sel};

endmodule

`default_nettype wire

### rtl/bgm_checker.sv
// port-level checks for the greedy bipartite matching core, bound to the top level
// depends on bgm_pkg
`default_nettype none

module bgm_checker
  import bgm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic [CMD_W-1:0]     in_cmd,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [STAT_W-1:0]    out_status,
  input wire logic [VTX_W-1:0]     out_pair_a,
  input wire logic [VTX_W-1:0]     out_pair_b,
  input wire logic                 out_last
);

  // an accepted edge or run transaction keeps the block busy for the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd != CMD_NONE) |=> in_stall)
    else $error("input not stalled after a command transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_pair_a) && $stable(out_pair_b) && $stable(out_last))
    else $error("stalled result changed");

  // only matched pairs can leave last low
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PAIR) |-> out_last && (out_pair_a == '0) &&
      (out_pair_b == '0))
    else $error("non-pair result with last low or nonzero vertices");

  // a matched pair names real vertices
  a_pair_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_PAIR) |-> (out_pair_a != '0) && (out_pair_b != '0) &&
      (out_pair_a <= MAX_A_V) && (out_pair_b <= MAX_B_V))
    else $error("matched pair with vertex out of range");

endmodule

bind bipartite_greedy_matching_core bgm_checker u_bgm_checker (.*);

`default_nettype wire
